FILE: sv/tmg_pkg.sv
// tmg_pkg: shared types, codes and constants of the touch-to-mouse gesture engine
// used by the frame memory, the divider, the top level and the benches; the stream interface carries its payload types
`default_nettype none
package tmg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 17;
  localparam int SCALE_W   = 9;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 9'd256;
  localparam logic [7:0]  SCAN_MIN   = 8'd15;
  localparam logic [7:0]  SCAN_MAX   = 8'd255;
  localparam logic [31:0] BMS_LIMIT  = 32'd1500;
  localparam logic [31:0] JIT_BTN    = 32'd1009;
  localparam logic [31:0] JIT_PTR    = 32'd209;
  localparam logic [15:0] DIV9_MUL   = 16'd58255;
  localparam int          DIV9_SHIFT = 19;
  localparam logic [14:0] RATIO_MUL  = 15'd25600;
  localparam logic [15:0] MINOR_LO   = 16'd600;
  localparam logic [15:0] MINOR_HI   = 16'd850;
  localparam logic [7:0]  PRS_A_LO   = 8'd20;
  localparam logic [7:0]  PRS_A_HI   = 8'd25;
  localparam logic [7:0]  PRS_B_HI   = 8'd75;
  localparam logic [DIV_DEN_W-1:0] SAMPLE_DEN_A = 17'd750;
  localparam logic [DIV_DEN_W-1:0] SAMPLE_DEN_B = 17'd800;
  localparam logic [DIV_DEN_W-1:0] AVG_DEN      = 17'd3;
  localparam logic [1:0]  NUM_SAMPLES = 2'd3;

  localparam int NUM_ROLES = 5;
  localparam int R_PTR = 0;
  localparam int R_WHL = 1;
  localparam int R_LFT = 2;
  localparam int R_RGT = 3;
  localparam int R_MID = 4;

  localparam logic REPORT_MOUSE = 1'b0;
  localparam logic REPORT_PASS  = 1'b1;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN  = 3'd0,
    CFG_Y_TOP     = 3'd1,
    CFG_TRACK     = 3'd2,
    CFG_NEAR      = 3'd3,
    CFG_CLOSED    = 3'd4,
    CFG_FAR       = 3'd5,
    CFG_DIVISOR   = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TRK_RD, S_TRK_EV, S_DECIDE, S_RP_RD, S_RP_M1, S_RP_M2,
    S_BT_RD, S_BT_SQ, S_BT_EV, S_JIT, S_MO_RD, S_MO_SET, S_MO_DIV,
    S_SCALE, S_SC_DIV, S_OUT, S_PASS_RD, S_PASS_MUL, S_PASS_EMIT, S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0]        frame_time;
    logic               has_fingers;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         pressure;
    logic [15:0]        tool_major;
    logic [15:0]        tool_minor;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic              report_kind;
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [2:0]        contact_id;
    logic              contact_tip;
    logic [12:0]       contact_x;
    logic [12:0]       contact_y;
    logic [3:0]        contact_count;
    logic [7:0]        scan_time;
    logic              last_of_report;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         pressure;
    logic [15:0]        major;
    logic [15:0]        minor;
  } contact_t;

  typedef struct packed {
    logic [7:0]  ratio;
    logic [10:0] length;
  } ptr_lim_t;

  // shape limits of a first pointer, by pressure band
  function automatic ptr_lim_t ptr_limits(input logic [7:0] p);
    ptr_lim_t l;
    if (p < 8'd4) begin
      l = '{ratio: 8'd170, length: 11'd800};
    end else if (p < 8'd8) begin
      l = '{ratio: 8'd160, length: 11'd900};
    end else if (p < 8'd12) begin
      l = '{ratio: 8'd150, length: 11'd1000};
    end else if (p < 8'd16) begin
      l = '{ratio: 8'd145, length: 11'd1200};
    end else begin
      l = '{ratio: 8'd140, length: 11'd1350};
    end
    return l;
  endfunction

  function automatic logic [15:0] mag17(input logic signed [16:0] v);
    logic signed [16:0] a;
    a = (v < 0) ? -v : v;
    return a[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/tmg_stream_if.sv
// tmg_stream_if: valid/ready channel carrying one payload of type T
// payload types come from tmg_pkg
`default_nettype none
interface tmg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/tmg_frame_mem.sv
// tmg_frame_mem: contact store of the frame being evaluated
// one write port, one read port with registered data; uses tmg_pkg
`default_nettype none
module tmg_frame_mem #(
  parameter int DEPTH = 10,
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  tmg_pkg::contact_t   wdata,
  input  logic [AW-1:0]       raddr,
  output tmg_pkg::contact_t   rdata
);
  import tmg_pkg::*;

  contact_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/tmg_div.sv
// tmg_div: restoring divider, one quotient bit per cycle
// widths from tmg_pkg
`default_nettype none
module tmg_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tmg_pkg::DIV_NUM_W-1:0]     num,
  input  logic [tmg_pkg::DIV_DEN_W-1:0]     den,
  output logic                              busy,
  output logic                              done,
  output logic [tmg_pkg::DIV_NUM_W-1:0]     quo
);
  import tmg_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [CW-1:0]        cnt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NUM_W);
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= diff[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/touch_to_mouse_gesture_engine.sv
// touch_to_mouse_gesture_engine: frame loader, role sequencer and report output
// uses tmg_pkg, tmg_stream_if, tmg_frame_mem and tmg_div
//
// Usage: contacts of one touch frame enter on in_ch, one transaction each; the
// transaction with is_last set closes the frame. Closing a frame starts an
// evaluation over the frame memory: tracking, button search, one division
// per motion axis and one for a scale update in the shared divider; in_ch is
// not ready meanwhile. A passthrough frame reads, scales and emits each
// contact in turn.
// out_ch carries one mouse report per frame, or up to PASS_CONTACTS contact
// transactions in wheel mode, the last flagged by last_of_report. Results sit
// in an output register; while out_ch stalls the sequencer waits there.
// Frames of MAX_CONTACTS or more contacts give no result.
// cfg_we writes register cfg_idx with cfg_wdata; write only idle.
// rst (synchronous) clears the frame and the roles and sets the finger scale to
// SCALE_ONE; no clearing pass is needed.
`default_nettype none
module touch_to_mouse_gesture_engine #(
  parameter int MAX_CONTACTS  = 10,
  parameter int PASS_CONTACTS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  tmg_stream_if.sink                          in_ch,
  tmg_stream_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [tmg_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tmg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tmg_pkg::*;

  localparam int IDX_W = $clog2(MAX_CONTACTS);
  localparam int CNT_W = $clog2(MAX_CONTACTS + 1);

  // configuration
  logic signed [15:0] x_origin;
  logic signed [15:0] y_top;
  logic [14:0] track_offset, near_distance, closed_distance, far_distance;
  logic [7:0]  pointer_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin        <= '0;
      y_top           <= '0;
      track_offset    <= 15'd600;
      near_distance   <= 15'd1200;
      closed_distance <= 15'd1600;
      far_distance    <= 15'd4800;
      pointer_divisor <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_X_ORIGIN: x_origin        <= cfg_wdata;
        CFG_Y_TOP:    y_top           <= cfg_wdata;
        CFG_TRACK:    track_offset    <= cfg_wdata[14:0];
        CFG_NEAR:     near_distance   <= cfg_wdata[14:0];
        CFG_CLOSED:   closed_distance <= cfg_wdata[14:0];
        CFG_FAR:      far_distance    <= cfg_wdata[14:0];
        CFG_DIVISOR:  pointer_divisor <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // frame loading
  in_item_t          itm;
  logic              in_acc;
  logic [CNT_W-1:0]  fill;
  logic              mem_we;
  logic [CNT_W-1:0]  fill_inc;
  contact_t          mem_wdata;
  contact_t          rdata;
  logic [IDX_W-1:0]  raddr;

  assign itm          = in_ch.data;
  assign in_ch.ready  = (state == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign mem_we       = in_acc && itm.has_fingers && (fill < CNT_W'(MAX_CONTACTS));
  assign fill_inc     = fill + CNT_W'(mem_we);
  assign mem_wdata    = '{x: itm.pos_x, y: itm.pos_y, pressure: itm.pressure,
                          major: itm.tool_major, minor: itm.tool_minor};

  // frame and role state
  logic [CNT_W-1:0]  n_frm, prior_count, idx, idx_inc, pass_m;
  logic [31:0]       cur_t, prior_time, pointer_start, jitter_start, tdelta;
  logic [7:0]        scan;
  logic              prv_v [NUM_ROLES];
  logic signed [15:0] rp_x [NUM_ROLES];
  logic signed [15:0] rp_y [NUM_ROLES];
  logic              cur_v [NUM_ROLES];
  logic [IDX_W-1:0]  cur_i [NUM_ROLES];
  logic signed [15:0] nw_x [NUM_ROLES];
  logic signed [15:0] nw_y [NUM_ROLES];
  logic [2:0]        seen;
  logic              wheel_on, judge;
  logic [SCALE_W-1:0] finger_scale;
  logic [SCALE_W-1:0] samples [3];
  logic [1:0]        smp_cnt;

  assign idx_inc = idx + CNT_W'(1);
  assign tdelta  = itm.frame_time - prior_time;
  always_comb begin
    if (int'(n_frm) > PASS_CONTACTS) begin
      pass_m = CNT_W'(PASS_CONTACTS);
    end else begin
      pass_m = n_frm;
    end
  end

  // tracking against the previous roles
  logic [NUM_ROLES-1:0] tr;
  always_comb begin
    for (int k = 0; k < NUM_ROLES; k++) begin
      tr[k] = prv_v[k]
        && (mag17($signed({rdata.x[15], rdata.x}) - $signed({rp_x[k][15], rp_x[k]}))
            < {1'b0, track_offset})
        && (mag17($signed({rdata.y[15], rdata.y}) - $signed({rp_y[k][15], rp_y[k]}))
            < {1'b0, track_offset});
    end
  end

  // real pointer test registers
  ptr_lim_t    lim;
  logic [24:0] rp_ms;
  logic [30:0] rp_mj;
  logic [19:0] rp_ls;
  logic [7:0]  rp_r;
  logic [15:0] rp_maj;
  logic        rp_nz;
  logic signed [15:0] rp0_x, rp0_y;
  logic [32:0] rp_prod;
  logic        rp_ok;

  assign lim     = ptr_limits(rdata.pressure);
  assign rp_prod = rp_ms * rp_r;
  assign rp_ok   = rp_nz && ({2'b0, rp_mj} < rp_prod) && ({rp_maj, 8'b0} < {4'b0, rp_ls});

  // button search
  logic [29:0] nr2, cl2, fr2;
  logic [31:0] bdx2, bdy2;
  logic        bneg, bpos;
  logic signed [15:0] bx, by;
  logic signed [16:0] bdx, bdy;
  logic [32:0] d2;
  logic        bms_ok, skip, wheel_hit;

  assign bdx    = $signed({rdata.x[15], rdata.x}) - $signed({nw_x[R_PTR][15], nw_x[R_PTR]});
  assign bdy    = $signed({rdata.y[15], rdata.y}) - $signed({nw_y[R_PTR][15], nw_y[R_PTR]});
  assign d2     = {1'b0, bdx2} + {1'b0, bdy2};
  assign bms_ok = (cur_t - pointer_start) < BMS_LIMIT;
  assign wheel_hit = judge && (d2 > {3'b0, nr2}) && (d2 < {3'b0, fr2}) && bms_ok;
  always_comb begin
    skip = 1'b0;
    for (int k = 0; k < NUM_ROLES; k++) begin
      if (cur_v[k] && (cur_i[k] == idx[IDX_W-1:0])) begin
        skip = 1'b1;
      end
    end
  end

  // jitter window
  logic jit_go;
  assign jit_go = (cur_t - jitter_start) > (cur_v[R_MID] ? JIT_BTN : JIT_PTR);

  // motion
  logic                 axis, mo_neg;
  logic [7:0]           mo_p;
  logic [15:0]          mo_mn;
  logic [DIV_DEN_W-1:0] mo_den;
  logic [SCALE_W-1:0]   sc_eff;
  logic [7:0]           sens_eff;
  logic signed [16:0]   mo_d;
  logic [15:0]          mo_m;
  logic [23:0]          mo_m256;
  logic                 mo_btn, mo_zero, mo_fine;
  logic signed [7:0]    dxo, dyo, sat_pos, sat_neg;
  logic                 sc_avg;
  logic [10:0]          smp_sum;

  assign sc_eff   = (finger_scale == '0) ? SCALE_W'(1) : finger_scale;
  assign sens_eff = (pointer_divisor == '0) ? 8'd1 : pointer_divisor;
  assign mo_d     = axis
    ? $signed({nw_y[R_PTR][15], nw_y[R_PTR]}) - $signed({rp_y[R_PTR][15], rp_y[R_PTR]})
    : $signed({nw_x[R_PTR][15], nw_x[R_PTR]}) - $signed({rp_x[R_PTR][15], rp_x[R_PTR]});
  assign mo_m     = mag17(mo_d);
  assign mo_m256  = {mo_m, 8'b0};
  assign mo_btn   = cur_v[R_LFT] || cur_v[R_RGT] || cur_v[R_MID];
  assign mo_zero  = mo_btn && (mo_m256 <= 24'(sc_eff * 4'd10));
  assign mo_fine  = mo_m256 <= 24'(sc_eff * 4'd5);
  assign smp_sum  = 11'(samples[0]) + 11'(samples[1]) + 11'(samples[2]);

  // shared divider
  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 smp_a, smp_b;

  assign smp_a = (mo_mn > MINOR_LO) && (mo_mn < MINOR_HI) && (mo_p > PRS_A_LO)
              && (mo_p < PRS_A_HI);
  assign smp_b = (mo_mn > MINOR_LO) && (mo_mn < MINOR_HI) && (mo_p > PRS_A_HI)
              && (mo_p < PRS_B_HI);

  always_comb begin
    if (div_quo > DIV_NUM_W'(127)) begin
      sat_pos = 8'sd127;
    end else begin
      sat_pos = div_quo[7:0];
    end
    if (div_quo > DIV_NUM_W'(128)) begin
      sat_neg = -8'sd128;
    end else begin
      sat_neg = 8'(8'd0 - div_quo[7:0]);
    end
  end

  // passthrough
  logic [31:0] pmx, pmy;
  logic        ptip;
  logic signed [16:0] px, py;
  assign px = $signed({rdata.x[15], rdata.x}) - $signed({x_origin[15], x_origin});
  assign py = $signed({y_top[15], y_top}) - $signed({rdata.y[15], rdata.y});

  // output register
  out_item_t obuf, ores;
  logic      ovalid, o_free, load;
  assign o_free        = !ovalid || out_ch.ready;
  assign out_ch.valid  = ovalid;
  assign out_ch.data   = obuf;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && itm.is_last && (fill_inc < CNT_W'(MAX_CONTACTS))) begin
          state_next = (fill_inc == '0) ? S_DECIDE : S_TRK_RD;
        end
      end
      S_TRK_RD: state_next = S_TRK_EV;
      S_TRK_EV: state_next = (idx_inc == n_frm) ? S_DECIDE : S_TRK_RD;
      S_DECIDE: begin
        if (!prv_v[R_PTR]) begin
          state_next = (n_frm != '0) ? S_RP_RD : S_OUT;
        end else if (!cur_v[R_PTR]) begin
          state_next = S_OUT;
        end else if (!wheel_on) begin
          state_next = (n_frm > CNT_W'(1)) ? S_BT_RD : S_JIT;
        end else begin
          state_next = S_PASS_RD;
        end
      end
      S_RP_RD: state_next = S_RP_M1;
      S_RP_M1: state_next = S_RP_M2;
      S_RP_M2: state_next = S_OUT;
      S_BT_RD: begin
        if (!skip) begin
          state_next = S_BT_SQ;
        end else if (idx_inc == n_frm) begin
          state_next = S_JIT;
        end
      end
      S_BT_SQ: state_next = S_BT_EV;
      S_BT_EV: state_next = (wheel_hit || (idx_inc == n_frm)) ? S_JIT : S_BT_RD;
      S_JIT: begin
        if (n_frm != prior_count) begin
          state_next = S_OUT;
        end else begin
          state_next = jit_go ? S_MO_RD : S_OUT;
        end
      end
      S_MO_RD:  state_next = S_MO_SET;
      S_MO_SET: state_next = S_MO_DIV;
      S_MO_DIV: begin
        if (div_done) begin
          state_next = axis ? S_SCALE : S_MO_SET;
        end
      end
      S_SCALE: begin
        if (smp_cnt == NUM_SAMPLES || smp_a || smp_b) begin
          state_next = S_SC_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SC_DIV:   state_next = div_done ? S_OUT : S_SC_DIV;
      S_OUT:      state_next = o_free ? S_FIN : S_OUT;
      S_PASS_RD:  state_next = S_PASS_MUL;
      S_PASS_MUL: state_next = S_PASS_EMIT;
      S_PASS_EMIT: begin
        if (o_free) begin
          state_next = (idx_inc == pass_m) ? S_FIN : S_PASS_RD;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr     = idx[IDX_W-1:0];
    div_start = 1'b0;
    div_num   = '0;
    div_den   = mo_den;
    load      = 1'b0;
    ores      = '0;
    case (state)
      S_RP_RD: raddr = '0;
      S_MO_RD: raddr = cur_i[R_PTR];
      S_MO_SET: begin
        div_start = 1'b1;
        if (mo_zero) begin
          div_num = '0;
        end else if (mo_fine) begin
          div_num = DIV_NUM_W'({mo_m, 9'b0});
        end else begin
          div_num = DIV_NUM_W'({mo_m, 8'b0});
        end
      end
      S_SCALE: begin
        if (smp_cnt == NUM_SAMPLES) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(smp_sum);
          div_den   = AVG_DEN;
        end else if (smp_a || smp_b) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'({mo_mn, 8'b0});
          div_den   = smp_a ? SAMPLE_DEN_A : SAMPLE_DEN_B;
        end
      end
      S_OUT: begin
        load = o_free;
        ores.report_kind    = REPORT_MOUSE;
        ores.buttons        = seen;
        ores.delta_x        = dxo;
        ores.delta_y        = dyo;
        ores.last_of_report = 1'b1;
      end
      S_PASS_EMIT: begin
        load = o_free;
        ores.report_kind    = REPORT_PASS;
        ores.contact_id     = 3'(idx);
        ores.contact_tip    = ptip;
        ores.contact_x      = pmx[DIV9_SHIFT+12:DIV9_SHIFT];
        ores.contact_y      = pmy[DIV9_SHIFT+12:DIV9_SHIFT];
        ores.contact_count  = 4'(n_frm);
        ores.scan_time      = scan;
        ores.last_of_report = (idx_inc == pass_m);
      end
      default: ;
    endcase
  end

  tmg_frame_mem #(.DEPTH(MAX_CONTACTS), .AW(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill[IDX_W-1:0]),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
    if (load) begin
      obuf <= ores;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      prior_count   <= '0;
      prior_time    <= '0;
      pointer_start <= '0;
      jitter_start  <= '0;
      wheel_on      <= 1'b0;
      judge         <= 1'b1;
      finger_scale  <= SCALE_ONE;
      smp_cnt       <= '0;
      for (int k = 0; k < 3; k++) begin
        samples[k] <= '0;
      end
      for (int k = 0; k < NUM_ROLES; k++) begin
        prv_v[k] <= 1'b0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            fill <= fill_inc;
            if (itm.is_last) begin
              fill <= '0;
              if (fill_inc < CNT_W'(MAX_CONTACTS)) begin
                n_frm      <= fill_inc;
                cur_t      <= itm.frame_time;
                prior_time <= itm.frame_time;
                if (tdelta < 32'(SCAN_MIN)) begin
                  scan <= SCAN_MIN;
                end else if (tdelta >= 32'(SCAN_MAX)) begin
                  scan <= SCAN_MAX;
                end else begin
                  scan <= tdelta[7:0];
                end
                idx  <= '0;
                seen <= '0;
                dxo  <= '0;
                dyo  <= '0;
                for (int k = 0; k < NUM_ROLES; k++) begin
                  cur_v[k] <= 1'b0;
                end
              end
            end
          end
        end
        S_TRK_EV: begin
          // first matching role wins, later contacts overwrite
          for (int k = 0; k < NUM_ROLES; k++) begin
            if (tr[k] && ((tr & ((NUM_ROLES)'(1) << k) - 1'b1) == '0)) begin
              cur_v[k] <= 1'b1;
              cur_i[k] <= idx[IDX_W-1:0];
              nw_x[k]  <= rdata.x;
              nw_y[k]  <= rdata.y;
              if (k >= R_LFT) begin
                seen[k-R_LFT] <= 1'b1;
              end
            end
          end
          idx <= idx_inc;
        end
        S_DECIDE: begin
          nr2 <= near_distance * near_distance;
          cl2 <= closed_distance * closed_distance;
          fr2 <= far_distance * far_distance;
          idx <= '0;
          if (prv_v[R_PTR] && !cur_v[R_PTR]) begin
            wheel_on <= 1'b0;
            judge    <= 1'b1;
            for (int k = R_WHL; k < NUM_ROLES; k++) begin
              cur_v[k] <= 1'b0;
            end
          end
        end
        S_RP_M1: begin
          rp_ms  <= rdata.minor * finger_scale;
          rp_mj  <= rdata.major * RATIO_MUL;
          rp_ls  <= lim.length * finger_scale;
          rp_r   <= lim.ratio;
          rp_maj <= rdata.major;
          rp_nz  <= (rdata.minor != '0);
          rp0_x  <= rdata.x;
          rp0_y  <= rdata.y;
        end
        S_RP_M2: begin
          if (rp_ok) begin
            cur_v[R_PTR]  <= 1'b1;
            cur_i[R_PTR]  <= '0;
            nw_x[R_PTR]   <= rp0_x;
            nw_y[R_PTR]   <= rp0_y;
            pointer_start <= cur_t;
          end
        end
        S_BT_RD: begin
          if (skip) begin
            idx <= idx_inc;
          end
        end
        S_BT_SQ: begin
          bdx2 <= mag17(bdx) * mag17(bdx);
          bdy2 <= mag17(bdy) * mag17(bdy);
          bneg <= bdx < 0;
          bpos <= bdx > 0;
          bx   <= rdata.x;
          by   <= rdata.y;
        end
        S_BT_EV: begin
          idx <= idx_inc;
          if (wheel_hit) begin
            wheel_on     <= 1'b1;
            judge        <= 1'b0;
            cur_v[R_WHL] <= 1'b1;
            cur_i[R_WHL] <= idx[IDX_W-1:0];
            nw_x[R_WHL]  <= bx;
            nw_y[R_WHL]  <= by;
            cur_v[R_LFT] <= 1'b0;
            cur_v[R_RGT] <= 1'b0;
            cur_v[R_MID] <= 1'b0;
          end else if (!cur_v[R_MID] && d2 > {3'b0, nr2} && d2 < {3'b0, cl2} && bneg) begin
            seen[2]      <= 1'b1;
            cur_v[R_MID] <= 1'b1;
            cur_i[R_MID] <= idx[IDX_W-1:0];
            nw_x[R_MID]  <= bx;
            nw_y[R_MID]  <= by;
          end else if (!cur_v[R_LFT] && d2 > {3'b0, cl2} && d2 < {3'b0, fr2} && bneg) begin
            seen[0]      <= 1'b1;
            cur_v[R_LFT] <= 1'b1;
            cur_i[R_LFT] <= idx[IDX_W-1:0];
            nw_x[R_LFT]  <= bx;
            nw_y[R_LFT]  <= by;
          end else if (!cur_v[R_RGT] && d2 > {3'b0, nr2} && d2 < {3'b0, fr2} && bpos) begin
            seen[1]      <= 1'b1;
            cur_v[R_RGT] <= 1'b1;
            cur_i[R_RGT] <= idx[IDX_W-1:0];
            nw_x[R_RGT]  <= bx;
            nw_y[R_RGT]  <= by;
          end
        end
        S_JIT: begin
          if (n_frm != prior_count) begin
            jitter_start <= cur_t;
          end
        end
        S_MO_RD: begin
          mo_den <= DIV_DEN_W'(sc_eff * sens_eff);
          axis   <= 1'b0;
        end
        S_MO_SET: begin
          mo_neg <= mo_d < 0;
          if (!axis) begin
            mo_p  <= rdata.pressure;
            mo_mn <= rdata.minor;
          end
        end
        S_MO_DIV: begin
          if (div_done) begin
            axis <= 1'b1;
            if (!axis) begin
              dxo <= mo_neg ? sat_neg : sat_pos;
            end else begin
              dyo <= mo_neg ? sat_pos : sat_neg;
            end
          end
        end
        S_SCALE: begin
          sc_avg <= (smp_cnt == NUM_SAMPLES);
        end
        S_SC_DIV: begin
          if (div_done) begin
            if (sc_avg) begin
              finger_scale <= div_quo[SCALE_W-1:0];
              smp_cnt      <= '0;
            end else begin
              samples[smp_cnt] <= div_quo[SCALE_W-1:0];
              smp_cnt          <= smp_cnt + 2'd1;
            end
          end
        end
        S_PASS_MUL: begin
          // divide by nine through a reciprocal multiply
          pmx  <= (px < 0) ? '0 : px[15:0] * DIV9_MUL;
          pmy  <= (py < 0) ? '0 : py[15:0] * DIV9_MUL;
          ptip <= (rdata.pressure != '0);
        end
        S_PASS_EMIT: begin
          if (o_free) begin
            idx <= idx_inc;
          end
        end
        S_FIN: begin
          prior_count <= n_frm;
          for (int k = 0; k < NUM_ROLES; k++) begin
            prv_v[k] <= cur_v[k];
            rp_x[k]  <= nw_x[k];
            rp_y[k]  <= nw_y[k];
          end
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_CONTACTS))
    else $error("fill count beyond frame capacity");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (load && state == S_PASS_EMIT) |-> (idx < pass_m))
    else $error("passthrough index beyond contact limit");

  a_ptr_role: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && cur_v[R_PTR]) |-> (CNT_W'(cur_i[R_PTR]) < n_frm))
    else $error("pointer role outside the frame");

endmodule
`default_nettype wire

FILE: bench/gesture_report_checker.sv
// gesture_report_checker: watches the contact, report and register ports of the gesture engine,
// predicts every report from the accepted contacts and compares; uses tmg_pkg types and codes
`timescale 1ns / 1ps
module gesture_report_checker
  import tmg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  localparam int MAXC  = 10;
  localparam int PASSC = 5;

  out_item_t   predicted_reports[$];
  longint      frm_x[MAXC], frm_y[MAXC], frm_p[MAXC], frm_maj[MAXC], frm_min[MAXC];
  longint      prv_x[MAXC], prv_y[MAXC];
  int          fill, prv_cnt;
  int          role_prev[NUM_ROLES];
  bit          wheel_on, wheel_judge;
  logic [31:0] ptr_t0, jit_t0, prv_time;
  longint      scale, nsamp;
  longint      samples[3];
  longint      x_org, y_org, trk, near_d, clo_d, far_d, divr;

  initial fail_count = 0;
  initial pending = 0;

  task automatic clear_state();
    for (int i = 0; i < MAXC; i++) begin
      frm_x[i] = 0; frm_y[i] = 0; frm_p[i] = 0; frm_maj[i] = 0; frm_min[i] = 0;
      prv_x[i] = 0; prv_y[i] = 0;
    end
    for (int k = 0; k < NUM_ROLES; k++) role_prev[k] = -1;
    fill = 0; prv_cnt = 0; wheel_on = 0; wheel_judge = 1;
    ptr_t0 = '0; jit_t0 = '0; prv_time = '0;
    scale = 256; nsamp = 0; samples[0] = 0; samples[1] = 0; samples[2] = 0;
    x_org = 0; y_org = 0; trk = 600; near_d = 1200; clo_d = 1600; far_d = 4800; divr = 4;
  endtask

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip8(longint v);
    return (v > 127) ? 127 : ((v < -128) ? -128 : v);
  endfunction

  function automatic bit follows(int i, int p);
    if (p < 0) return 0;
    return absl(frm_x[i] - prv_x[p]) < trk && absl(frm_y[i] - prv_y[p]) < trk;
  endfunction

  // pressure banded shape and length test on contact 0
  function automatic bit pointer_shape_ok();
    longint r, l;
    if (frm_p[0] < 4) begin r = 170; l = 800; end
    else if (frm_p[0] < 8) begin r = 160; l = 900; end
    else if (frm_p[0] < 12) begin r = 150; l = 1000; end
    else if (frm_p[0] < 16) begin r = 145; l = 1200; end
    else begin r = 140; l = 1350; end
    if (frm_min[0] == 0) return 0;
    return frm_maj[0] * 25600 < r * frm_min[0] * scale && frm_maj[0] * 256 < l * scale;
  endfunction

  function automatic longint axis_motion(longint d, bit btn);
    longint sc, sens, m, q;
    sc = (scale != 0) ? scale : 1;
    sens = (divr != 0) ? divr : 1;
    m = absl(d);
    if (btn && m * 256 <= 10 * sc) m = 0;
    if (m * 256 <= 5 * sc) q = m * 512 / (sc * sens);
    else q = m * 256 / (sc * sens);
    return (d < 0) ? -q : q;
  endfunction

  task automatic evaluate_frame(logic [31:0] cur);
    int n, m, cp, cw, cl, cr, cm, pp, pw, pl, pr, pm;
    bit sl, sr, sm, pass, btn;
    longint dxo, dyo, dx, dy, d2, x, y;
    logic [31:0] scan_d, bms, elapsed;
    out_item_t r;
    n = fill;
    fill = 0;
    if (n >= MAXC) return;
    cp = -1; cw = -1; cl = -1; cr = -1; cm = -1;
    pp = role_prev[R_PTR]; pw = role_prev[R_WHL]; pl = role_prev[R_LFT];
    pr = role_prev[R_RGT]; pm = role_prev[R_MID];
    sl = 0; sr = 0; sm = 0; pass = 0; dxo = 0; dyo = 0;
    scan_d = cur - prv_time;
    prv_time = cur;
    if (scan_d < 15) scan_d = 15;
    else if (scan_d >= 255) scan_d = 255;

    for (int i = 0; i < n; i++) begin
      if (follows(i, pp)) begin cp = i; continue; end
      if (follows(i, pw)) begin cw = i; continue; end
      if (follows(i, pl)) begin sl = 1; cl = i; continue; end
      if (follows(i, pr)) begin sr = 1; cr = i; continue; end
      if (follows(i, pm)) begin sm = 1; cm = i; continue; end
    end

    if (pp < 0 && n > 0) begin
      if (pointer_shape_ok()) begin
        cp = 0;
        ptr_t0 = cur;
      end
    end else if (cp < 0 && pp >= 0) begin
      wheel_on = 0; wheel_judge = 1;
      cw = -1; cl = -1; cr = -1; cm = -1;
    end else if (cp >= 0 && !wheel_on) begin
      bms = (cur - ptr_t0) / 10;
      if (n > 1) begin
        for (int i = 0; i < n; i++) begin
          if (i == cp || i == cl || i == cr || i == cm || i == cw) continue;
          dx = frm_x[i] - frm_x[cp];
          dy = frm_y[i] - frm_y[cp];
          d2 = dx * dx + dy * dy;
          if (wheel_judge && d2 > near_d * near_d && d2 < far_d * far_d && bms < 150) begin
            wheel_on = 1; wheel_judge = 0;
            cw = i; cl = -1; cr = -1; cm = -1;
            break;
          end
          if (cm < 0 && d2 > near_d * near_d && d2 < clo_d * clo_d && dx < 0) begin
            sm = 1; cm = i;
          end else if (cl < 0 && d2 > clo_d * clo_d && d2 < far_d * far_d && dx < 0) begin
            sl = 1; cl = i;
          end else if (cr < 0 && d2 > near_d * near_d && d2 < far_d * far_d && dx > 0) begin
            sr = 1; cr = i;
          end
        end
      end
      elapsed = cur - jit_t0;
      if (n != prv_cnt) begin
        jit_t0 = cur;
      end else if (elapsed / 10 > ((cm >= 0) ? 100 : 20)) begin
        btn = cl >= 0 || cr >= 0 || cm >= 0;
        dxo = clip8(axis_motion(frm_x[cp] - prv_x[pp], btn));
        dyo = clip8(-axis_motion(frm_y[cp] - prv_y[pp], btn));
        if (nsamp < 3) begin
          if (frm_min[cp] > 600 && frm_min[cp] < 850) begin
            if (frm_p[cp] > 20 && frm_p[cp] < 25) begin
              samples[nsamp] = frm_min[cp] * 256 / 750; nsamp++;
            end else if (frm_p[cp] > 25 && frm_p[cp] < 75) begin
              samples[nsamp] = frm_min[cp] * 256 / 800; nsamp++;
            end
          end
        end else begin
          scale = (samples[0] + samples[1] + samples[2]) / 3;
          nsamp = 0;
        end
      end
    end else if (cp >= 0 && wheel_on) begin
      pass = 1;
    end

    if (pass) begin
      m = (n > PASSC) ? PASSC : n;
      for (int i = 0; i < m; i++) begin
        x = frm_x[i] - x_org;
        y = y_org - frm_y[i];
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        r = '0;
        r.report_kind = REPORT_PASS;
        r.contact_id = i;
        r.contact_tip = frm_p[i] > 0;
        r.contact_x = x / 9;
        r.contact_y = y / 9;
        r.contact_count = n;
        r.scan_time = scan_d[7:0];
        r.last_of_report = (i == m - 1);
        predicted_reports.push_back(r);
      end
    end else begin
      r = '0;
      r.report_kind = REPORT_MOUSE;
      r.buttons = {sm, sr, sl};
      r.delta_x = dxo;
      r.delta_y = dyo;
      r.last_of_report = 1'b1;
      predicted_reports.push_back(r);
    end

    for (int i = 0; i < n; i++) begin
      prv_x[i] = frm_x[i];
      prv_y[i] = frm_y[i];
    end
    prv_cnt = n;
    role_prev[R_PTR] = cp; role_prev[R_WHL] = cw; role_prev[R_LFT] = cl;
    role_prev[R_RGT] = cr; role_prev[R_MID] = cm;
  endtask

  task automatic store_contact(in_item_t it);
    if (it.has_fingers && fill < MAXC) begin
      frm_x[fill] = it.pos_x;
      frm_y[fill] = it.pos_y;
      frm_p[fill] = it.pressure;
      frm_maj[fill] = it.tool_major;
      frm_min[fill] = it.tool_minor;
      fill++;
    end
    if (it.is_last) evaluate_frame(it.frame_time);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (cfg_reg_t'(idx))
      CFG_X_ORIGIN: x_org = $signed(v);
      CFG_Y_TOP:    y_org = $signed(v);
      CFG_TRACK:    trk = v[14:0];
      CFG_NEAR:     near_d = v[14:0];
      CFG_CLOSED:   clo_d = v[14:0];
      CFG_FAR:      far_d = v[14:0];
      CFG_DIVISOR:  divr = v[7:0];
      default: ;
    endcase
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    bit bad;
    if (predicted_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected report: %p", got);
      return;
    end
    want = predicted_reports.pop_front();
    bad = got.report_kind !== want.report_kind || got.buttons !== want.buttons ||
          got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
          got.contact_id !== want.contact_id || got.contact_tip !== want.contact_tip ||
          got.contact_x !== want.contact_x || got.contact_y !== want.contact_y ||
          got.contact_count !== want.contact_count || got.scan_time !== want.scan_time ||
          got.last_of_report !== want.last_of_report;
    if (bad) begin
      fail_count++;
      if (fail_count <= 10) $display("report mismatch: expected %p got %p", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      predicted_reports.delete();
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (cfg_we) write_reg(cfg_idx, cfg_wdata);
      if (in_valid && in_ready) store_contact(in_data);
    end
    pending = predicted_reports.size();
  end
endmodule

FILE: bench/tb_touch_to_mouse_gesture_engine.sv
// tb_touch_to_mouse_gesture_engine: drives touch frames and register writes into the engine
// and gives the verdict; needs tmg_pkg, tmg_stream_if, the engine and gesture_report_checker
`timescale 1ns / 1ps
module tb_touch_to_mouse_gesture_engine;
  import tmg_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int   send_idle_pct, recv_idle_pct;
  logic recv_hold;
  int   contacts_sent;
  int   fail_count, pending;
  int   fx[12], fy[12], fp[12], fmaj[12], fmin[12];
  logic [31:0] now;

  tmg_stream_if #(.T(in_item_t))  in_ch();
  tmg_stream_if #(.T(out_item_t)) out_ch();

  touch_to_mouse_gesture_engine uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  gesture_report_checker report_check (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic hold_receiver(int cycles);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  // valid is left high after a transaction; the next call lowers or keeps it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.has_fingers) contacts_sent++;
  endtask

  task automatic send_frame(int n, logic [31:0] t);
    in_item_t it;
    for (int i = 0; i < n || (n == 0 && i == 0); i++) begin
      if (n > 0 && $urandom_range(9) == 0) begin
        // contact-free filler inside the frame
        it = {$urandom, $urandom, $urandom, $urandom};
        it.has_fingers = 1'b0;
        it.is_last = 1'b0;
        send_item(it);
      end
      it.frame_time = t;
      it.has_fingers = (n > 0);
      it.pos_x = fx[i];
      it.pos_y = fy[i];
      it.pressure = fp[i];
      it.tool_major = fmaj[i];
      it.tool_minor = fmin[i];
      it.is_last = (i == n - 1) || (n == 0);
      send_item(it);
    end
  endtask

  task automatic set_contact(int i, int x, int y, int p, int maj, int mnr);
    fx[i] = x; fy[i] = y; fp[i] = p; fmaj[i] = maj; fmin[i] = mnr;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_config(int xo, int yt, int trk, int near_d, int clo_d, int far_d,
                              int divr);
    cfg_reg_t r;
    int v;
    for (int k = 0; k < 7; k++) begin
      r = cfg_reg_t'(k);
      case (r)
        CFG_X_ORIGIN: v = xo;
        CFG_Y_TOP:    v = yt;
        CFG_TRACK:    v = trk;
        CFG_NEAR:     v = near_d;
        CFG_CLOSED:   v = clo_d;
        CFG_FAR:      v = far_d;
        default:      v = divr;
      endcase
      cfg_we <= 1'b1;
      cfg_idx <= r;
      cfg_wdata <= v[15:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // a held pointer, an optional wheel or button finger and at times stray extra contacts
  task automatic run_gesture();
    int px, py, frames, role, off, n, extra;
    bit helper_on;
    px = int'($urandom_range(40000)) - 20000;
    py = int'($urandom_range(40000)) - 20000;
    frames = $urandom_range(4, 14);
    role = $urandom_range(0, 3);
    helper_on = 0;
    for (int f = 0; f < frames; f++) begin
      now += ($urandom_range(4) == 0) ? $urandom_range(1, 14) : $urandom_range(15, 400);
      px += int'($urandom_range(300)) - 150;
      py += int'($urandom_range(300)) - 150;
      if (f == 1 || $urandom_range(5) == 0) helper_on = !helper_on;
      case (role)
        0: off = 2000;
        1: off = -2500;
        2: off = 2500;
        default: off = -1350;
      endcase
      set_contact(0, px, py, $urandom_range(21, 74), $urandom_range(600, 900),
                  $urandom_range(620, 840));
      n = 1;
      if (helper_on) begin
        set_contact(1, px + off, py + int'($urandom_range(200)) - 100, $urandom_range(1, 80),
                    $urandom_range(500, 900), $urandom_range(500, 850));
        n = 2;
        if ($urandom_range(3) == 0) begin
          extra = $urandom_range(1, 5);
          for (int k = 0; k < extra; k++) begin
            set_contact(n, px + int'($urandom_range(8000)) - 4000,
                        py + int'($urandom_range(8000)) - 4000, $urandom_range(0, 255),
                        $urandom_range(0, 2000), $urandom_range(0, 2000));
            n++;
          end
        end
      end
      send_frame(n, now);
    end
    now += $urandom_range(15, 300);
    send_frame(0, now);
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(0, 11);
    for (int i = 0; i < n; i++) begin
      set_contact(i, int'($urandom) % 32768, int'($urandom) % 32768, $urandom_range(255),
                  $urandom_range(65535), $urandom_range(65535));
      fx[i] = $signed(16'($urandom));
      fy[i] = $signed(16'($urandom));
    end
    send_frame(n, $urandom);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int count, bit with_hold);
    int goal;
    goal = contacts_sent + count;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (with_hold) fork hold_receiver(600); join_none
    while (contacts_sent < goal) begin
      if ($urandom_range(9) < 8) run_gesture();
      else run_noise();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    recv_hold <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 71;
    contacts_sent = 0;
    now = 32'd1000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frame, then first pointer, wheel entry and a capped passthrough
    send_frame(0, 32'd50);
    set_contact(0, 1000, 1000, 30, 700, 650);
    send_frame(1, 32'd100);
    set_contact(1, 3000, 1000, 40, 700, 650);
    send_frame(2, 32'd150);
    set_contact(2, 32767, -32768, 0, 65535, 0);
    set_contact(3, -32768, 32767, 255, 0, 65535);
    set_contact(4, -1, 0, 1, 1, 1);
    set_contact(5, 20000, 20000, 10, 10, 10);
    send_frame(6, 32'd160);
    // pointer lifted while wheel was active
    send_frame(0, 32'd5000);
    // oversized frame with extreme fields gives no report
    for (int i = 0; i < 10; i++) begin
      set_contact(i, (i % 2) ? 32767 : -32768, (i % 2) ? -32768 : 32767,
                  (i % 2) ? 255 : 0, (i % 2) ? 65535 : 0, 0);
    end
    send_frame(10, 32'hFFFF_FFFF);
    // zero minor axis fails the shape test
    set_contact(0, 0, 0, 2, 500, 0);
    send_frame(1, 32'd3);
    settle();

    write_config(int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) + 20000,
                 $urandom_range(300, 900), $urandom_range(1000, 1300),
                 $urandom_range(1500, 1800), $urandom_range(4000, 6000),
                 $urandom_range(1, 8));
    run_phase(32, 71, 140, 1);
    // sender waits until every report has arrived
    settle();
    write_config(-32768, 32767, 32767, 0, 0, 32767, 255);
    run_phase(71, 32, 140, 0);
    settle();
    write_config(32767, -32768, 600, 1200, 1600, 4800, 1);
    run_phase(0, 0, 140, 1);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/tmg_pkg.sv
sv/tmg_stream_if.sv
sv/tmg_frame_mem.sv
sv/tmg_div.sv
sv/touch_to_mouse_gesture_engine.sv
bench/gesture_report_checker.sv
bench/tb_touch_to_mouse_gesture_engine.sv
